// ===== rtl/core/pcs_pkg.sv =====
// Package for the polygon centroid block: beat payload types, controller
// states, the controller-to-datapath command and status bundles and sizes.
// No dependencies.
package pcs_pkg;

    localparam int COORD_W  = 16;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int SUM_W    = COORD_W + 1;
    localparam int MOM_W    = SUM_W + CROSS_W;
    localparam int XSUM_W   = 48;
    localparam int MSUM_W   = 64;
    localparam int DEN_W    = XSUM_W + 2;
    localparam int QUOT_W   = COORD_W + 1;
    localparam int DIV_STEPS = QUOT_W;
    localparam int DCNT_W   = $clog2(DIV_STEPS);
    localparam int DVS_W    = DEN_W + COORD_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic                      last_vertex;
    } t_vertex;

    typedef struct packed {
        logic signed [COORD_W-1:0] centroid_x;
        logic signed [COORD_W-1:0] centroid_y;
        logic                      degenerate;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CROSS,
        ST_MOM,
        ST_ACC,
        ST_PREP,
        ST_START_X,
        ST_WAIT_X,
        ST_START_Y,
        ST_WAIT_Y,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic cap;
        logic mul;
        logic xprod;
        logic mom;
        logic acc;
        logic load_close;
        logic prep;
        logic div_start;
        logic sel_y;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic closing;
        logic degen;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/pcs_divider.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Top quotient bit flags a quotient of 2^16 or more. Uses pcs_pkg.
module pcs_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcs_pkg::MSUM_W-1:0]    i_num,
    input  logic [pcs_pkg::DEN_W-1:0]     i_den,
    output logic                          o_done,
    output logic [pcs_pkg::QUOT_W-1:0]    o_quot
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [pcs_pkg::DCNT_W-1:0]    r_cnt, n_cnt;
    logic [pcs_pkg::MSUM_W-1:0]    r_rem, n_rem;
    logic [pcs_pkg::DVS_W-1:0]     r_dvs, n_dvs;
    logic [pcs_pkg::QUOT_W-1:0]    r_quot, n_quot;
    logic [pcs_pkg::DVS_W-1:0]     rem_ext;
    logic                          ge;

    assign rem_ext = {{(pcs_pkg::DVS_W - pcs_pkg::MSUM_W){1'b0}}, r_rem};
    assign ge      = rem_ext >= r_dvs;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num;
            n_dvs  = {i_den, {pcs_pkg::COORD_W{1'b0}}};
            n_quot = '0;
        end else if (r_busy) begin
            if (ge) begin
                n_rem = r_rem - r_dvs[pcs_pkg::MSUM_W-1:0];
            end
            n_quot = {r_quot[pcs_pkg::QUOT_W-2:0], ge};
            n_dvs  = r_dvs >> 1;
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == pcs_pkg::DCNT_W'(pcs_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/core/pcs_datapath.sv =====
// Datapath: vertex and edge registers, cross and moment products,
// accumulators, divider operands and the result register.
// Uses pcs_pkg and pcs_divider.
module pcs_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcs_pkg::t_dp_cmd   i_cmd,
    output pcs_pkg::t_dp_stat  o_stat,
    input  pcs_pkg::t_vertex   i_vertex,
    output logic               o_result_valid,
    input  logic               i_result_ready,
    output pcs_pkg::t_result   o_result
);

    localparam int CW = pcs_pkg::COORD_W;

    function automatic logic [CW-1:0] sat_q(input logic [pcs_pkg::QUOT_W-1:0] q,
                                            input logic neg);
        logic [pcs_pkg::QUOT_W-1:0] mag;
        logic [pcs_pkg::QUOT_W-1:0] lim_n;
        logic [pcs_pkg::QUOT_W-1:0] lim_p;
        lim_n = pcs_pkg::QUOT_W'(1) << (CW - 1);
        lim_p = lim_n - 1'b1;
        if (neg) begin
            mag   = (q > lim_n) ? lim_n : q;
            sat_q = CW'(~mag + 1'b1);
        end else begin
            mag   = (q > lim_p) ? lim_p : q;
            sat_q = mag[CW-1:0];
        end
    endfunction

    logic signed [CW-1:0]                r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic                                r_seen, r_last, r_closing;
    logic signed [CW-1:0]                r_ax, r_ay, r_bx, r_by;
    logic signed [pcs_pkg::PROD_W-1:0]   r_p1, r_p2;
    logic signed [pcs_pkg::SUM_W-1:0]    r_sx, r_sy;
    logic signed [pcs_pkg::CROSS_W-1:0]  r_c;
    logic signed [pcs_pkg::MOM_W-1:0]    r_mx, r_my;
    logic [pcs_pkg::XSUM_W-1:0]          r_cross_sum;
    logic [pcs_pkg::MSUM_W-1:0]          r_mom_x, r_mom_y;
    logic [pcs_pkg::MSUM_W-1:0]          r_num_x, r_num_y;
    logic [pcs_pkg::DEN_W-1:0]           r_den;
    logic                                r_neg_x, r_neg_y, r_degen;
    logic [pcs_pkg::QUOT_W-1:0]          r_qx, r_qy;
    logic                                r_out_valid;
    pcs_pkg::t_result                    r_out, n_out;

    logic [pcs_pkg::XSUM_W-1:0]          cross_mag;
    logic                                div_done;
    logic [pcs_pkg::QUOT_W-1:0]          div_quot;

    assign cross_mag = r_cross_sum[pcs_pkg::XSUM_W-1] ? (~r_cross_sum + 1'b1) : r_cross_sum;

    pcs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (i_cmd.sel_y ? r_num_y : r_num_x),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_out = '0;
        n_out.degenerate = r_degen;
        if (!r_degen) begin
            n_out.centroid_x = sat_q(r_qx, r_neg_x);
            n_out.centroid_y = sat_q(r_qy, r_neg_y);
        end
    end

    // vertex registers and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_seen      <= 1'b0;
            r_cross_sum <= '0;
            r_mom_x     <= '0;
            r_mom_y     <= '0;
        end else begin
            if (i_cmd.cap) begin
                if (!r_seen) begin
                    r_first_x <= i_vertex.vertex_x;
                    r_first_y <= i_vertex.vertex_y;
                end
                r_prev_x <= i_vertex.vertex_x;
                r_prev_y <= i_vertex.vertex_y;
                r_seen   <= 1'b1;
            end
            if (i_cmd.acc) begin
                r_cross_sum <= r_cross_sum
                             + {{(pcs_pkg::XSUM_W - pcs_pkg::CROSS_W){r_c[pcs_pkg::CROSS_W-1]}}, r_c};
                r_mom_x <= r_mom_x
                         + {{(pcs_pkg::MSUM_W - pcs_pkg::MOM_W){r_mx[pcs_pkg::MOM_W-1]}}, r_mx};
                r_mom_y <= r_mom_y
                         + {{(pcs_pkg::MSUM_W - pcs_pkg::MOM_W){r_my[pcs_pkg::MOM_W-1]}}, r_my};
            end
        end
    end

    // flags and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= 1'b0;
            r_closing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cap) begin
                r_last    <= i_vertex.last_vertex;
                r_closing <= 1'b0;
            end else if (i_cmd.load_close) begin
                r_closing <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // edge pipeline, divider operands and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_ax <= r_seen ? r_prev_x : i_vertex.vertex_x;
            r_ay <= r_seen ? r_prev_y : i_vertex.vertex_y;
            r_bx <= i_vertex.vertex_x;
            r_by <= i_vertex.vertex_y;
        end else if (i_cmd.load_close) begin
            r_ax <= r_prev_x;
            r_ay <= r_prev_y;
            r_bx <= r_first_x;
            r_by <= r_first_y;
        end
        if (i_cmd.mul) begin
            r_p1 <= r_ax * r_by;
            r_p2 <= r_bx * r_ay;
            r_sx <= {r_ax[CW-1], r_ax} + {r_bx[CW-1], r_bx};
            r_sy <= {r_ay[CW-1], r_ay} + {r_by[CW-1], r_by};
        end
        if (i_cmd.xprod) begin
            r_c <= {r_p1[pcs_pkg::PROD_W-1], r_p1} - {r_p2[pcs_pkg::PROD_W-1], r_p2};
        end
        if (i_cmd.mom) begin
            r_mx <= r_sx * r_c;
            r_my <= r_sy * r_c;
        end
        if (i_cmd.prep) begin
            r_num_x <= r_mom_x[pcs_pkg::MSUM_W-1] ? (~r_mom_x + 1'b1) : r_mom_x;
            r_num_y <= r_mom_y[pcs_pkg::MSUM_W-1] ? (~r_mom_y + 1'b1) : r_mom_y;
            r_neg_x <= r_mom_x[pcs_pkg::MSUM_W-1] ^ r_cross_sum[pcs_pkg::XSUM_W-1];
            r_neg_y <= r_mom_y[pcs_pkg::MSUM_W-1] ^ r_cross_sum[pcs_pkg::XSUM_W-1];
            r_den   <= {2'b00, cross_mag} + {1'b0, cross_mag, 1'b0};
            r_degen <= (r_cross_sum == '0);
        end
        if (div_done) begin
            if (i_cmd.sel_y) begin
                r_qy <= div_quot;
            end else begin
                r_qx <= div_quot;
            end
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_stat.last     = r_last;
    assign o_stat.closing  = r_closing;
    assign o_stat.degen    = r_degen;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || i_result_ready;

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

// ===== rtl/core/pcs_ctrl.sv =====
// Controller: sequences vertex capture, the per-edge product steps, the
// closing edge and, unless the polygon is degenerate, the two divisions. Uses pcs_pkg.
module pcs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vertex_valid,
    output logic               o_vertex_ready,
    input  pcs_pkg::t_dp_stat  i_stat,
    output pcs_pkg::t_dp_cmd   o_cmd
);

    pcs_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pcs_pkg::ST_IDLE: begin
                if (i_vertex_valid) n_state = pcs_pkg::ST_MUL;
            end
            pcs_pkg::ST_MUL:   n_state = pcs_pkg::ST_CROSS;
            pcs_pkg::ST_CROSS: n_state = pcs_pkg::ST_MOM;
            pcs_pkg::ST_MOM:   n_state = pcs_pkg::ST_ACC;
            pcs_pkg::ST_ACC: begin
                if (!i_stat.last) begin
                    n_state = pcs_pkg::ST_IDLE;
                end else if (!i_stat.closing) begin
                    n_state = pcs_pkg::ST_MUL;
                end else begin
                    n_state = pcs_pkg::ST_PREP;
                end
            end
            pcs_pkg::ST_PREP: n_state = pcs_pkg::ST_START_X;
            pcs_pkg::ST_START_X: begin
                n_state = i_stat.degen ? pcs_pkg::ST_OUT : pcs_pkg::ST_WAIT_X;
            end
            pcs_pkg::ST_WAIT_X: begin
                if (i_stat.div_done) n_state = pcs_pkg::ST_START_Y;
            end
            pcs_pkg::ST_START_Y: n_state = pcs_pkg::ST_WAIT_Y;
            pcs_pkg::ST_WAIT_Y: begin
                if (i_stat.div_done) n_state = pcs_pkg::ST_OUT;
            end
            pcs_pkg::ST_OUT: begin
                if (i_stat.out_free) n_state = pcs_pkg::ST_IDLE;
            end
            default: n_state = pcs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_vertex_ready = 1'b0;
        case (r_state)
            pcs_pkg::ST_IDLE: begin
                o_vertex_ready = 1'b1;
                o_cmd.cap      = i_vertex_valid;
            end
            pcs_pkg::ST_MUL:   o_cmd.mul   = 1'b1;
            pcs_pkg::ST_CROSS: o_cmd.xprod = 1'b1;
            pcs_pkg::ST_MOM:   o_cmd.mom   = 1'b1;
            pcs_pkg::ST_ACC: begin
                o_cmd.acc        = 1'b1;
                o_cmd.load_close = i_stat.last && !i_stat.closing;
            end
            pcs_pkg::ST_PREP:    o_cmd.prep      = 1'b1;
            pcs_pkg::ST_START_X: o_cmd.div_start = !i_stat.degen;
            pcs_pkg::ST_WAIT_X:  o_cmd.sel_y     = 1'b0;
            pcs_pkg::ST_START_Y: begin
                o_cmd.div_start = 1'b1;
                o_cmd.sel_y     = 1'b1;
            end
            pcs_pkg::ST_WAIT_Y:  o_cmd.sel_y     = 1'b1;
            pcs_pkg::ST_OUT:     o_cmd.load_out  = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/polygon_centroid_shoelace.sv =====
// Polygon centroid by the shoelace formula: top level, controller plus datapath.
// Uses pcs_pkg, pcs_ctrl and pcs_datapath.
//
// One vertex (signed Q8.8) per input beat; the beat flagged last_vertex closes
// the polygon and yields one result beat, centroid = moment / (3 * cross sum),
// truncated toward zero and saturated to Q8.8, or zero with degenerate set when
// the area is zero. Each vertex is accepted, then taken through four product
// and accumulate steps in the edge datapath. The last vertex adds the closing
// edge, operand setup, one division per axis in the shared bit-serial divider
// (start, 17 quotient bits, done) and the result load; a degenerate polygon
// skips both divisions. The result load waits for the result register to free.
// The result register lets the next polygon's vertices start while a result
// beat is still held.
module polygon_centroid_shoelace (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vertex_valid,
    output logic              o_vertex_ready,
    input  pcs_pkg::t_vertex  i_vertex,
    output logic              o_result_valid,
    input  logic              i_result_ready,
    output pcs_pkg::t_result  o_result
);

    pcs_pkg::t_dp_cmd  cmd;
    pcs_pkg::t_dp_stat stat;

    pcs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_valid (i_vertex_valid),
        .o_vertex_ready (o_vertex_ready),
        .i_stat         (stat),
        .o_cmd          (cmd)
    );

    pcs_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_vertex       (i_vertex),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_result       (o_result)
    );

endmodule

// ===== dv/testbench.sv =====
// Testbench for polygon_centroid_shoelace: streams directed and random polygons,
// predicts each centroid beat with a scoreboard class and checks it field by field.
// Depends on pcs_pkg and the polygon_centroid_shoelace RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES   = 1_000_000;
    localparam int TOTAL_VERTICES = 1050;
    localparam int TAIL_CYCLES    = 64;
    localparam int BIG_POLYGON    = 300;

    typedef enum int {
        SH_FULL,
        SH_LOCAL,
        SH_LINE,
        SH_POINT,
        SH_EXTREME
    } t_shape;

    class centroid_scoreboard;
        logic signed [pcs_pkg::COORD_W-1:0] first_x, first_y, prev_x, prev_y;
        logic [63:0]                        moment_x, moment_y;
        logic [47:0]                        cross_acc;
        bit                                 seen;
        pcs_pkg::t_result                   expected_q[$];
        int                                 errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            first_x   = '0;
            first_y   = '0;
            prev_x    = '0;
            prev_y    = '0;
            moment_x  = '0;
            moment_y  = '0;
            cross_acc = '0;
            seen      = 1'b0;
        endfunction

        function void report(string msg);
            if (errors < 50) begin
                $display("MISMATCH @%0t: %s", $realtime, msg);
            end
            errors++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_edge(logic signed [pcs_pkg::COORD_W-1:0] ax,
                               logic signed [pcs_pkg::COORD_W-1:0] ay,
                               logic signed [pcs_pkg::COORD_W-1:0] bx,
                               logic signed [pcs_pkg::COORD_W-1:0] by);
            longint c;
            longint mx;
            longint my;
            c  = longint'(ax) * longint'(by) - longint'(bx) * longint'(ay);
            mx = (longint'(ax) + longint'(bx)) * c;
            my = (longint'(ay) + longint'(by)) * c;
            cross_acc = cross_acc + c[47:0];
            moment_x  = moment_x + mx;
            moment_y  = moment_y + my;
        endfunction

        // truncating divide, clamped to Q8.8
        function logic [pcs_pkg::COORD_W-1:0] div_q88(longint num, longint den);
            logic [63:0] un;
            logic [63:0] ud;
            logic [63:0] q;
            bit          neg;
            neg = (num < 0) != (den < 0);
            un  = num;
            ud  = den;
            if (num < 0) un = -un;
            if (den < 0) ud = -ud;
            q = un / ud;
            if (neg) begin
                if (q > 64'd32768) q = 64'd32768;
                q = -q;
                return q[pcs_pkg::COORD_W-1:0];
            end
            if (q > 64'd32767) q = 64'd32767;
            return q[pcs_pkg::COORD_W-1:0];
        endfunction

        function void note_vertex(pcs_pkg::t_vertex v);
            longint           cs;
            longint           den;
            pcs_pkg::t_result r;
            if (!seen) begin
                first_x = v.vertex_x;
                first_y = v.vertex_y;
                seen    = 1'b1;
            end else begin
                add_edge(prev_x, prev_y, v.vertex_x, v.vertex_y);
            end
            prev_x = v.vertex_x;
            prev_y = v.vertex_y;
            if (v.last_vertex) begin
                add_edge(prev_x, prev_y, first_x, first_y);
                cs = {{16{cross_acc[47]}}, cross_acc};
                if (cs == 0) begin
                    r.centroid_x = '0;
                    r.centroid_y = '0;
                    r.degenerate = 1'b1;
                end else begin
                    den = 3 * cs;
                    r.centroid_x = div_q88(longint'(moment_x), den);
                    r.centroid_y = div_q88(longint'(moment_y), den);
                    r.degenerate = 1'b0;
                end
                expected_q = {expected_q, r};
                clear();
            end
        endfunction

        function void check_result(pcs_pkg::t_result got);
            pcs_pkg::t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat with none expected: x=%0d y=%0d degenerate=%0b",
                                 got.centroid_x, got.centroid_y, got.degenerate));
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            if (got.centroid_x !== want.centroid_x)
                report($sformatf("centroid_x got %0d expected %0d",
                                 got.centroid_x, want.centroid_x));
            if (got.centroid_y !== want.centroid_y)
                report($sformatf("centroid_y got %0d expected %0d",
                                 got.centroid_y, want.centroid_y));
            if (got.degenerate !== want.degenerate)
                report($sformatf("degenerate got %0b expected %0b",
                                 got.degenerate, want.degenerate));
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
                report($sformatf("%0d result beats never arrived", expected_q.size()));
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_vertex_valid;
    logic             o_vertex_ready;
    pcs_pkg::t_vertex i_vertex;
    logic             o_result_valid;
    logic             i_result_ready;
    pcs_pkg::t_result o_result;

    centroid_scoreboard sb;
    bit                 calm;
    int                 vertices_sent;
    int                 stall_left;
    int                 ready_roll;
    int unsigned        cycles;

    polygon_centroid_shoelace u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_valid (i_vertex_valid),
        .o_vertex_ready (o_vertex_ready),
        .i_vertex       (i_vertex),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_result       (o_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid && i_result_ready) sb.check_result(o_result);
            if (i_vertex_valid && o_vertex_ready) sb.note_vertex(i_vertex);
        end
    end

    // result side back-pressure: mostly short stalls, a few long
    always @(posedge i_clk) begin
        if (calm) begin
            i_result_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_result_ready <= 1'b0;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 65) begin
                i_result_ready <= 1'b1;
            end else begin
                stall_left = (ready_roll < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
                i_result_ready <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 4);
        return $urandom_range(15, 50);
    endfunction

    function automatic logic [pcs_pkg::COORD_W-1:0] pick_extreme();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'h7FFE;
            default: return 16'h7FFF;
        endcase
    endfunction

    task automatic send_vertex(input pcs_pkg::t_vertex v);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_vertex_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_vertex       <= v;
        i_vertex_valid <= 1'b1;
        do @(posedge i_clk); while (!o_vertex_ready);
        vertices_sent++;
    endtask

    task automatic send_xy(input int x, input int y, input bit last);
        pcs_pkg::t_vertex v;
        v.vertex_x    = 16'(x);
        v.vertex_y    = 16'(y);
        v.last_vertex = last;
        send_vertex(v);
    endtask

    // hold off the sender until every centroid beat is back
    task automatic drain();
        i_vertex_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic send_polygon(input int n, input t_shape shape);
        pcs_pkg::t_vertex             v;
        logic [pcs_pkg::COORD_W-1:0]  cx, cy;
        int                           span;
        int                           bx, by, dx, dy, t;
        cx   = 16'($urandom);
        cy   = 16'($urandom);
        span = 1 << $urandom_range(2, 11);
        bx   = $urandom_range(0, 2000) - 1000;
        by   = $urandom_range(0, 2000) - 1000;
        dx   = $urandom_range(0, 40) - 20;
        dy   = $urandom_range(0, 40) - 20;
        for (int k = 0; k < n; k++) begin
            case (shape)
                SH_FULL: begin
                    v.vertex_x = 16'($urandom);
                    v.vertex_y = 16'($urandom);
                end
                SH_LOCAL: begin
                    v.vertex_x = cx + 16'($urandom_range(0, 2 * span) - span);
                    v.vertex_y = cy + 16'($urandom_range(0, 2 * span) - span);
                end
                SH_LINE: begin
                    t = $urandom_range(0, 20) - 10;
                    v.vertex_x = 16'(bx + t * dx);
                    v.vertex_y = 16'(by + t * dy);
                end
                SH_POINT: begin
                    v.vertex_x = cx;
                    v.vertex_y = cy;
                end
                default: begin
                    v.vertex_x = pick_extreme();
                    v.vertex_y = pick_extreme();
                end
            endcase
            v.last_vertex = (k == n - 1);
            send_vertex(v);
        end
    endtask

    initial begin
        int     polygons;
        int     n;
        int     roll;
        t_shape shape;

        sb             = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_vertex_valid = 1'b0;
        i_vertex       = '0;
        i_result_ready = 1'b0;
        calm           = 1'b0;
        stall_left     = 0;
        vertices_sent  = 0;
        cycles         = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lone last vertex closes onto itself
        send_xy(32767, -32768, 1);
        // two vertices: no area
        send_xy(-32768, -32768, 0);
        send_xy(32767, 32767, 1);
        // unit-ish triangle, both windings
        send_xy(0, 0, 0);
        send_xy(768, 0, 0);
        send_xy(0, 768, 1);
        send_xy(0, 0, 0);
        send_xy(0, 768, 0);
        send_xy(768, 0, 1);
        // full-range square
        send_xy(-32768, -32768, 0);
        send_xy(32767, -32768, 0);
        send_xy(32767, 32767, 0);
        send_xy(-32768, 32767, 1);
        // self-crossing bow tie
        send_xy(-32768, -32768, 0);
        send_xy(32767, 32767, 0);
        send_xy(32767, -32768, 0);
        send_xy(-32768, 32767, 1);
        // collinear
        send_xy(256, 256, 0);
        send_xy(512, 512, 0);
        send_xy(768, 768, 1);
        drain();

        polygons = 0;
        while (vertices_sent < TOTAL_VERTICES) begin
            calm = ($urandom_range(0, 4) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 70)      n = $urandom_range(3, 8);
            else if (roll < 85) n = $urandom_range(1, 2);
            else                n = $urandom_range(9, 40);
            roll = $urandom_range(0, 99);
            if (roll < 50)      shape = SH_FULL;
            else if (roll < 70) shape = SH_LOCAL;
            else if (roll < 80) shape = SH_LINE;
            else if (roll < 85) shape = SH_POINT;
            else                shape = SH_EXTREME;
            // one large full-range polygon; its sums stay within the accumulator widths
            if (polygons == 30) begin
                n     = BIG_POLYGON;
                shape = SH_FULL;
            end
            send_polygon(n, shape);
            if ($urandom_range(0, 39) == 0) drain();
            polygons++;
        end

        calm = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== polygon_centroid_shoelace.f =====
rtl/core/pcs_pkg.sv
rtl/core/pcs_divider.sv
rtl/core/pcs_datapath.sv
rtl/core/pcs_ctrl.sv
rtl/core/polygon_centroid_shoelace.sv
dv/testbench.sv
